[hdl/vdm_pkg.sv]
package vdm_pkg;

  // Element and result formats
  localparam int ELEM_W    = 16;
  localparam int FRAC_W    = 16;
  localparam int DIST_W    = 56;
  localparam int Q_W       = FRAC_W + 1;

  // Snapshot widths cover the largest supported vector length (4096 pairs)
  localparam int CNT_W_MAX = 13;
  localparam int SQ_W      = 2 * ELEM_W + CNT_W_MAX;
  localparam int AB_W      = ELEM_W + CNT_W_MAX;
  localparam int SX_W      = ELEM_W + CNT_W_MAX;
  localparam int SXY_W     = 2 * ELEM_W + CNT_W_MAX;
  localparam int SXX_W     = 2 * ELEM_W - 1 + CNT_W_MAX;

  // Working width of the shared arithmetic unit (signed statistics)
  localparam int PW        = 2 * CNT_W_MAX + 2 * ELEM_W + 1;

  // Queue between front and back
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = 2;
  localparam int QCNT_W    = 3;

  localparam logic [Q_W-1:0] ONE_FIX = {1'b1, {FRAC_W{1'b0}}};

  typedef enum logic [2:0] {
    M_EUCLID    = 3'd0,
    M_SQEUCLID  = 3'd1,
    M_CITYBLOCK = 3'd2,
    M_CHEBYCHEV = 3'd3,
    M_COSINE    = 3'd4,
    M_CORREL    = 3'd5,
    M_HAMMING   = 3'd6,
    M_JACCARD   = 3'd7
  } metric_t;

  typedef enum logic [1:0] {
    AR_MUL,
    AR_SQRT,
    AR_DIV
  } ar_op_t;

  typedef enum logic [1:0] {
    AS_IDLE,
    AS_RUN,
    AS_DONE
  } ar_state_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_DECODE,
    BK_MUL_GO,
    BK_MUL_WAIT,
    BK_SQRT_GO,
    BK_SQRT_WAIT,
    BK_DIV_GO,
    BK_DIV_WAIT,
    BK_OUT
  } bk_state_t;

  // Register map
  localparam logic [1:0] REG_METRIC = 2'd0;

  typedef struct packed {
    metric_t              metric;
    logic                 ovf;
    logic [CNT_W_MAX-1:0] n;
    logic [SQ_W-1:0]      sq;
    logic [AB_W-1:0]      ab;
    logic [ELEM_W-1:0]    mx;
    logic [SX_W-1:0]      sx;
    logic [SX_W-1:0]      sy;
    logic [SXY_W-1:0]     sxy;
    logic [SXX_W-1:0]     sxx;
    logic [SXX_W-1:0]     syy;
    logic [CNT_W_MAX-1:0] mism;
    logic [CNT_W_MAX-1:0] nz;
  } snap_t;

  typedef struct packed {
    logic              start;
    ar_op_t            op;
    logic [PW-1:0]     a;
    logic [PW-1:0]     b;
    logic [2*PW-1:0]   rad;
  } ar_req_t;

  typedef struct packed {
    logic              done;
    logic [2*PW-1:0]   prod;
    logic [PW-1:0]     root;
    logic [Q_W-1:0]    quo;
  } ar_rsp_t;

endpackage

[hdl/vdm_fifo.sv]
module vdm_fifo import vdm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  snap_t             wr_data,
  input  logic              rd_en,
  output snap_t             rd_data,
  output logic              q_empty,
  output logic [QCNT_W-1:0] q_count
);

  snap_t              mem [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_en ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = rd_en ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(wr_en) - QCNT_W'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  assign rd_data = mem[rd_ptr_r];
  assign q_empty = (cnt_r == '0);
  assign q_count = cnt_r;

endmodule

[hdl/vdm_front.sv]
module vdm_front import vdm_pkg::*; #(
  parameter int MAX_LENGTH = 256
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  logic signed [ELEM_W-1:0] x_elem,
  input  logic signed [ELEM_W-1:0] y_elem,
  input  logic                     last,
  input  metric_t                  metric,
  input  logic [QCNT_W-1:0]        q_count,
  output logic                     full,
  output logic                     q_push,
  output snap_t                    q_data
);

  localparam int CW   = $clog2(MAX_LENGTH + 1);
  localparam int SQW  = 2 * ELEM_W + CW;
  localparam int ABW  = ELEM_W + CW;
  localparam int SXW  = ELEM_W + CW;
  localparam int SXYW = 2 * ELEM_W + CW;
  localparam int SXXW = 2 * ELEM_W - 1 + CW;

  logic accept;

  // Product stage
  logic                       sa_valid_r;
  logic                       sa_last_r;
  logic signed [ELEM_W-1:0]   sa_x_r, sa_y_r;
  logic [ELEM_W-1:0]          sa_d_r;
  logic [2*ELEM_W-1:0]        sa_dd_r;
  logic signed [2*ELEM_W-1:0] sa_xy_r;
  logic [2*ELEM_W-2:0]        sa_xx_r, sa_yy_r;

  logic signed [ELEM_W:0]     diff;
  logic [ELEM_W-1:0]          d_abs;
  logic signed [2*ELEM_W-1:0] xx_full, yy_full;

  // Accumulators
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [SQW-1:0]         sq_r, sq_nxt;
  logic [ABW-1:0]         ab_r, ab_nxt;
  logic [ELEM_W-1:0]      mx_r, mx_nxt;
  logic signed [SXW-1:0]  sx_r, sx_nxt, sy_r, sy_nxt;
  logic signed [SXYW-1:0] sxy_r, sxy_nxt;
  logic [SXXW-1:0]        sxx_r, sxx_nxt, syy_r, syy_nxt;
  logic [CW-1:0]          mism_r, mism_nxt, nz_r, nz_nxt;
  logic                   ovf_r, ovf_nxt;
  logic                   take;

  // A last pair in the product stage is already owed a queue slot
  assign full   = (q_count + QCNT_W'(sa_valid_r & sa_last_r)) >= QCNT_W'(QDEPTH);
  assign accept = push & ~full;

  always_comb begin
    diff    = ELEM_W'(1) == 0 ? '0 : (ELEM_W+1)'(x_elem) - (ELEM_W+1)'(y_elem);
    d_abs   = diff[ELEM_W] ? ELEM_W'(-diff) : diff[ELEM_W-1:0];
    xx_full = x_elem * x_elem;
    yy_full = y_elem * y_elem;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_valid_r <= 1'b0;
    end else begin
      sa_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sa_last_r <= last;
      sa_x_r    <= x_elem;
      sa_y_r    <= y_elem;
      sa_d_r    <= d_abs;
      sa_dd_r   <= d_abs * d_abs;
      sa_xy_r   <= x_elem * y_elem;
      sa_xx_r   <= xx_full[2*ELEM_W-2:0];
      sa_yy_r   <= yy_full[2*ELEM_W-2:0];
    end
  end

  always_comb begin
    take     = cnt_r < CW'(MAX_LENGTH);
    cnt_nxt  = cnt_r;
    sq_nxt   = sq_r;
    ab_nxt   = ab_r;
    mx_nxt   = mx_r;
    sx_nxt   = sx_r;
    sy_nxt   = sy_r;
    sxy_nxt  = sxy_r;
    sxx_nxt  = sxx_r;
    syy_nxt  = syy_r;
    mism_nxt = mism_r;
    nz_nxt   = nz_r;
    ovf_nxt  = ovf_r;
    if (take) begin
      cnt_nxt  = cnt_r + 1'b1;
      sq_nxt   = sq_r + SQW'(sa_dd_r);
      ab_nxt   = ab_r + ABW'(sa_d_r);
      mx_nxt   = (sa_d_r > mx_r) ? sa_d_r : mx_r;
      sx_nxt   = sx_r + SXW'(sa_x_r);
      sy_nxt   = sy_r + SXW'(sa_y_r);
      sxy_nxt  = sxy_r + SXYW'(sa_xy_r);
      sxx_nxt  = sxx_r + SXXW'(sa_xx_r);
      syy_nxt  = syy_r + SXXW'(sa_yy_r);
      mism_nxt = mism_r + CW'(sa_x_r != sa_y_r);
      nz_nxt   = nz_r + CW'((sa_x_r != '0) || (sa_y_r != '0));
    end else begin
      ovf_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (sa_valid_r && sa_last_r)) begin
      cnt_r  <= '0;
      sq_r   <= '0;
      ab_r   <= '0;
      mx_r   <= '0;
      sx_r   <= '0;
      sy_r   <= '0;
      sxy_r  <= '0;
      sxx_r  <= '0;
      syy_r  <= '0;
      mism_r <= '0;
      nz_r   <= '0;
      ovf_r  <= 1'b0;
    end else if (sa_valid_r) begin
      cnt_r  <= cnt_nxt;
      sq_r   <= sq_nxt;
      ab_r   <= ab_nxt;
      mx_r   <= mx_nxt;
      sx_r   <= sx_nxt;
      sy_r   <= sy_nxt;
      sxy_r  <= sxy_nxt;
      sxx_r  <= sxx_nxt;
      syy_r  <= syy_nxt;
      mism_r <= mism_nxt;
      nz_r   <= nz_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

  // Hand the finished sums to the back end, widened to the snapshot format
  assign q_push = sa_valid_r & sa_last_r;

  always_comb begin
    q_data.metric = metric;
    q_data.ovf    = ovf_nxt;
    q_data.n      = CNT_W_MAX'(cnt_nxt);
    q_data.sq     = SQ_W'(sq_nxt);
    q_data.ab     = AB_W'(ab_nxt);
    q_data.mx     = mx_nxt;
    q_data.sx     = SX_W'(sx_nxt);
    q_data.sy     = SX_W'(sy_nxt);
    q_data.sxy    = SXY_W'(sxy_nxt);
    q_data.sxx    = SXX_W'(sxx_nxt);
    q_data.syy    = SXX_W'(syy_nxt);
    q_data.mism   = CNT_W_MAX'(mism_nxt);
    q_data.nz     = CNT_W_MAX'(nz_nxt);
  end

endmodule

[hdl/vdm_arith.sv]
module vdm_arith import vdm_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  ar_req_t req,
  output ar_rsp_t rsp
);

  localparam int CNT_W = $clog2(PW);

  ar_state_t          state_r, state_nxt;
  ar_op_t             op_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [2*PW-1:0]    acc_r;
  logic [PW+1:0]      rem_r;
  logic [PW-1:0]      res_r;
  logic [PW-1:0]      opnd_r;
  logic               neg_r;

  logic [PW-1:0]      mag_a, mag_b;
  logic [PW:0]        mul_sum;
  logic [PW+3:0]      sq_sh, sq_trial;
  logic [PW:0]        dv_sh;
  logic               div_sat;

  always_comb begin
    mag_a    = req.a[PW-1] ? -req.a : req.a;
    mag_b    = req.b[PW-1] ? -req.b : req.b;
    div_sat  = req.a >= req.b;
    mul_sum  = {1'b0, acc_r[2*PW-1:PW]} + (acc_r[0] ? {1'b0, opnd_r} : '0);
    sq_sh    = {rem_r, acc_r[2*PW-1:2*PW-2]};
    sq_trial = (PW+4)'({res_r, 2'b01});
    dv_sh    = {rem_r[PW-1:0], 1'b0};
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      AS_IDLE: begin
        if (req.start) begin
          state_nxt = (req.op == AR_DIV && div_sat) ? AS_DONE : AS_RUN;
        end
      end
      AS_RUN: begin
        if (cnt_r == '0) begin
          state_nxt = AS_DONE;
        end
      end
      AS_DONE: state_nxt = AS_IDLE;
      default: state_nxt = AS_IDLE;
    endcase
  end

  always_comb begin
    rsp.done = (state_r == AS_DONE);
    rsp.prod = neg_r ? -acc_r : acc_r;
    rsp.root = res_r;
    rsp.quo  = res_r[Q_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= AS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == AS_IDLE && req.start) begin
      op_r  <= req.op;
      case (req.op)
        AR_MUL: begin
          acc_r  <= {{PW{1'b0}}, mag_b};
          opnd_r <= mag_a;
          neg_r  <= req.a[PW-1] ^ req.b[PW-1];
          cnt_r  <= CNT_W'(PW - 1);
          rem_r  <= '0;
          res_r  <= '0;
        end
        AR_SQRT: begin
          acc_r <= req.rad;
          neg_r <= 1'b0;
          cnt_r <= CNT_W'(PW - 1);
          rem_r <= '0;
          res_r <= '0;
        end
        AR_DIV: begin
          rem_r  <= {2'b00, req.a};
          opnd_r <= req.b;
          neg_r  <= 1'b0;
          cnt_r  <= CNT_W'(FRAC_W - 1);
          res_r  <= div_sat ? PW'(ONE_FIX) : '0;
        end
        default: begin
          cnt_r <= '0;
          rem_r <= '0;
          res_r <= '0;
        end
      endcase
    end else if (state_r == AS_RUN) begin
      cnt_r <= cnt_r - 1'b1;
      case (op_r)
        AR_MUL: acc_r <= {mul_sum, acc_r[PW-1:1]};
        AR_SQRT: begin
          acc_r <= {acc_r[2*PW-3:0], 2'b00};
          if (sq_sh >= sq_trial) begin
            rem_r <= (PW+2)'(sq_sh - sq_trial);
            res_r <= {res_r[PW-2:0], 1'b1};
          end else begin
            rem_r <= (PW+2)'(sq_sh);
            res_r <= {res_r[PW-2:0], 1'b0};
          end
        end
        AR_DIV: begin
          if (dv_sh >= {1'b0, opnd_r}) begin
            rem_r <= (PW+2)'(dv_sh - {1'b0, opnd_r});
            res_r <= {res_r[PW-2:0], 1'b1};
          end else begin
            rem_r <= (PW+2)'(dv_sh);
            res_r <= {res_r[PW-2:0], 1'b0};
          end
        end
        default: acc_r <= acc_r;
      endcase
    end
  end

endmodule

[hdl/vdm_back.sv]
module vdm_back import vdm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  snap_t             q_data,
  input  logic              q_empty,
  output logic              q_pop,
  output ar_req_t           ar_req,
  input  ar_rsp_t           ar_rsp,
  input  logic              pop,
  output logic              empty,
  output logic [DIST_W-1:0] distance,
  output logic              too_long
);

  localparam logic [2:0] K_AB = 3'd6;

  bk_state_t         state_r, state_nxt;
  snap_t             snap_r;
  logic [2:0]        k_r;
  logic [PW-1:0]     t_r, n_r, a_r, b_r;
  logic [DIST_W-1:0] res_r;
  logic              out_valid_r;
  logic [DIST_W-1:0] out_dist_r;
  logic              out_tl_r;

  logic              ratio;
  logic              load_out;
  logic [PW-1:0]     prod_lo, stat_diff, n_mag;
  logic [PW-1:0]     mul_a, mul_b;

  assign ratio = (snap_r.metric == M_COSINE) || (snap_r.metric == M_CORREL);

  always_comb begin
    prod_lo   = ar_rsp.prod[PW-1:0];
    stat_diff = t_r - prod_lo;
    n_mag     = n_r[PW-1] ? -n_r : n_r;
    case (k_r)
      3'd0: begin
        mul_a = PW'(snap_r.n);
        mul_b = PW'($signed(snap_r.sxy));
      end
      3'd1: begin
        mul_a = PW'($signed(snap_r.sx));
        mul_b = PW'($signed(snap_r.sy));
      end
      3'd2: begin
        mul_a = PW'(snap_r.n);
        mul_b = PW'(snap_r.sxx);
      end
      3'd3: begin
        mul_a = PW'($signed(snap_r.sx));
        mul_b = PW'($signed(snap_r.sx));
      end
      3'd4: begin
        mul_a = PW'(snap_r.n);
        mul_b = PW'(snap_r.syy);
      end
      3'd5: begin
        mul_a = PW'($signed(snap_r.sy));
        mul_b = PW'($signed(snap_r.sy));
      end
      default: begin
        mul_a = a_r;
        mul_b = b_r;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: if (!q_empty) state_nxt = BK_DECODE;
      BK_DECODE: begin
        case (snap_r.metric)
          M_EUCLID:                        state_nxt = BK_SQRT_GO;
          M_COSINE, M_CORREL:              state_nxt = BK_MUL_GO;
          M_HAMMING:                       state_nxt = (snap_r.n == '0) ? BK_OUT : BK_DIV_GO;
          M_JACCARD:                       state_nxt = (snap_r.nz == '0) ? BK_OUT : BK_DIV_GO;
          default:                         state_nxt = BK_OUT;
        endcase
      end
      BK_MUL_GO:  state_nxt = BK_MUL_WAIT;
      BK_MUL_WAIT: begin
        if (ar_rsp.done) state_nxt = (k_r == K_AB) ? BK_SQRT_GO : BK_MUL_GO;
      end
      BK_SQRT_GO: state_nxt = BK_SQRT_WAIT;
      BK_SQRT_WAIT: begin
        if (ar_rsp.done) begin
          state_nxt = (ratio && ar_rsp.root != '0) ? BK_DIV_GO : BK_OUT;
        end
      end
      BK_DIV_GO:  state_nxt = BK_DIV_WAIT;
      BK_DIV_WAIT: if (ar_rsp.done) state_nxt = BK_OUT;
      BK_OUT:     if (load_out) state_nxt = BK_IDLE;
      default:    state_nxt = BK_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    q_pop        = (state_r == BK_IDLE) && !q_empty;
    load_out     = (state_r == BK_OUT) && (!out_valid_r || pop);
    ar_req.start = (state_r == BK_MUL_GO) || (state_r == BK_SQRT_GO) ||
                   (state_r == BK_DIV_GO);
    ar_req.op    = AR_MUL;
    ar_req.a     = mul_a;
    ar_req.b     = mul_b;
    ar_req.rad   = (snap_r.metric == M_EUCLID) ? (2*PW)'({snap_r.sq, 32'b0}) : ar_rsp.prod;
    case (state_r)
      BK_SQRT_GO: ar_req.op = AR_SQRT;
      BK_DIV_GO: begin
        ar_req.op = AR_DIV;
        if (ratio) begin
          ar_req.a = n_mag;
          ar_req.b = ar_rsp.root;
        end else begin
          ar_req.a = PW'(snap_r.mism);
          ar_req.b = (snap_r.metric == M_HAMMING) ? PW'(snap_r.n) : PW'(snap_r.nz);
        end
      end
      default: ar_req.op = AR_MUL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_dist_r <= res_r;
      out_tl_r   <= snap_r.ovf;
    end
    case (state_r)
      BK_IDLE: begin
        if (!q_empty) snap_r <= q_data;
      end
      BK_DECODE: begin
        k_r <= (snap_r.metric == M_COSINE) ? K_AB : 3'd0;
        case (snap_r.metric)
          M_SQEUCLID:  res_r <= DIST_W'({snap_r.sq, {FRAC_W{1'b0}}});
          M_CITYBLOCK: res_r <= DIST_W'({snap_r.ab, {FRAC_W{1'b0}}});
          M_CHEBYCHEV: res_r <= DIST_W'({snap_r.mx, {FRAC_W{1'b0}}});
          M_COSINE: begin
            res_r <= '0;
            n_r   <= PW'($signed(snap_r.sxy));
            a_r   <= PW'(snap_r.sxx);
            b_r   <= PW'(snap_r.syy);
          end
          default: res_r <= '0;
        endcase
      end
      BK_MUL_WAIT: begin
        if (ar_rsp.done) begin
          case (k_r)
            3'd1:    n_r <= stat_diff;
            3'd3:    a_r <= stat_diff;
            3'd5:    b_r <= stat_diff;
            default: t_r <= prod_lo;
          endcase
          if (k_r != K_AB) k_r <= k_r + 1'b1;
        end
      end
      BK_SQRT_WAIT: begin
        if (ar_rsp.done) begin
          res_r <= ratio ? DIST_W'(ONE_FIX) : DIST_W'(ar_rsp.root);
        end
      end
      BK_DIV_WAIT: begin
        if (ar_rsp.done) begin
          if (ratio) begin
            res_r <= n_r[PW-1] ? DIST_W'(ONE_FIX) + DIST_W'(ar_rsp.quo)
                               : DIST_W'(ONE_FIX) - DIST_W'(ar_rsp.quo);
          end else begin
            res_r <= DIST_W'(ar_rsp.quo);
          end
        end
      end
      default: res_r <= res_r;
    endcase
  end

  assign empty    = ~out_valid_r;
  assign distance = out_dist_r;
  assign too_long = out_tl_r;

endmodule

[hdl/multi_metric_vector_distance_core.sv]
// Streaming vector distance under one of eight metrics.
//
// Input channel (push/full, in_x_elem, in_y_elem, in_last): one element pair
// per item; in_last marks the final pair. Pairs beyond MAX_LENGTH are dropped
// and reported through out_too_long. Up to one pair is taken per cycle.
// Result channel (empty/pop, out_distance, out_too_long): one result per
// vector, unsigned fixed point with 16 fraction bits.
// Configuration (APB, register 0 at byte 0): metric, sampled when the last
// pair of a vector enters the accumulators; write it only while idle.
//
// The shared bit-serial multiply/root/divide unit in the back end serves
// the euclidean, hamming/jaccard, cosine and correlation metrics; the
// plain sums are finished without it. The front accumulates at one pair
// per cycle while the 4-entry queue between front and back has room.
// Reset clears the sums, the queue and the result valid flag, and sets the metric to euclidean.
// When the receiver stalls the result is held; the back end then waits and
// the queue fills, after which full rises and input stalls.
module multi_metric_vector_distance_core import vdm_pkg::*; #(
  parameter int MAX_LENGTH = 256
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // input channel
  input  logic                     push,
  output logic                     full,
  input  logic signed [ELEM_W-1:0] in_x_elem,
  input  logic signed [ELEM_W-1:0] in_y_elem,
  input  logic                     in_last,
  // result channel
  output logic                     empty,
  input  logic                     pop,
  output logic [DIST_W-1:0]        out_distance,
  output logic                     out_too_long,
  // configuration
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [1:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  metric_t           metric_r;
  logic              q_push, q_pop, q_empty;
  logic [QCNT_W-1:0] q_count;
  snap_t             q_wdata, q_rdata;
  ar_req_t           ar_req;
  ar_rsp_t           ar_rsp;

  // Metric register: write on the access phase, read back zero elsewhere
  assign pready = 1'b1;
  assign prdata = (paddr == REG_METRIC) ? {29'b0, metric_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      metric_r <= M_EUCLID;
    end else if (psel && penable && pwrite && pready && paddr == REG_METRIC) begin
      metric_r <= metric_t'(pwdata[2:0]);
    end
  end

  // Front end: accumulate pairs, hand completed vectors to the queue
  vdm_front #(
    .MAX_LENGTH(MAX_LENGTH)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .x_elem  (in_x_elem),
    .y_elem  (in_y_elem),
    .last    (in_last),
    .metric  (metric_r),
    .q_count (q_count),
    .full    (full),
    .q_push  (q_push),
    .q_data  (q_wdata)
  );

  vdm_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (q_wdata),
    .rd_en   (q_pop),
    .rd_data (q_rdata),
    .q_empty (q_empty),
    .q_count (q_count)
  );

  // Back end: finish one vector at a time on the shared iterative unit
  vdm_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_data   (q_rdata),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .ar_req   (ar_req),
    .ar_rsp   (ar_rsp),
    .pop      (pop),
    .empty    (empty),
    .distance (out_distance),
    .too_long (out_too_long)
  );

  vdm_arith u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (ar_req),
    .rsp   (ar_rsp)
  );

endmodule

[hdl/vdm_checker.sv]
module vdm_checker import vdm_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              full,
  input logic              pop,
  input logic              empty,
  input logic [DIST_W-1:0] out_distance,
  input logic              out_too_long
);

  // Reset leaves no result waiting
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result pending after reset");

  // Reset leaves the input open
  a_reset_open: assert property (@(posedge clk) !rst_n |=> !full)
    else $error("input blocked after reset");

  // A waiting result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_distance) && $stable(out_too_long)))
    else $error("waiting result changed");

endmodule

bind multi_metric_vector_distance_core vdm_checker u_vdm_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .full         (full),
  .pop          (pop),
  .empty        (empty),
  .out_distance (out_distance),
  .out_too_long (out_too_long)
);
